// ===== src/wav_stream_sample_decoder_top_assert.svh =====
// Assertion macros for the WAV stream sample decoder.
`ifndef WAV_STREAM_SAMPLE_DECODER_TOP_ASSERT_SVH
`define WAV_STREAM_SAMPLE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define WSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/wsd_pkg.sv =====
// Types, constants and conversion functions of the WAV stream sample decoder.
package wsd_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       is_last_byte;
  } in_t;

  typedef struct packed {
    logic        frame_valid;
    logic [31:0] left_sample;
    logic [31:0] right_sample;
    logic        end_of_file;
    logic [2:0]  status;
    logic [31:0] sample_rate;
  } out_t;

  typedef enum logic [2:0] {
    PH_RIFF, PH_HEAD, PH_FMT, PH_DATA, PH_SKIP, PH_DEAD
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_DIV, ST_FIN, ST_RES
  } ctrl_state_t;

  typedef enum logic [1:0] {
    KIND_OTHER, KIND_FMT, KIND_DATA
  } kind_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic fin;
    logic res;
  } wsd_cmd_t;

  typedef struct packed {
    logic need_div;
    logic has_res;
    logic div_done;
    logic out_free;
  } wsd_sts_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_UNSUPP    = 3'd3;
  localparam logic [2:0] ST_ALIGN     = 3'd4;
  localparam logic [2:0] ST_LIMIT     = 3'd5;

  localparam logic [31:0] TAG_RIFF = 32'h46464952;
  localparam logic [31:0] TAG_WAVE = 32'h45564157;
  localparam logic [31:0] TAG_FMT  = 32'h20746d66;
  localparam logic [31:0] TAG_DATA = 32'h61746164;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;
  localparam logic [15:0] FMT_EXT   = 16'hfffe;
  localparam logic [31:0] GUID_W1   = 32'h00100000;
  localparam logic [31:0] GUID_W2   = 32'haa000080;
  localparam logic [31:0] GUID_W3   = 32'h719b3800;

  localparam logic [31:0] FRAME_LIMIT_RST = 32'h00100000;
  localparam logic [5:0]  MIN_FILE_LEN    = 6'd44;

  function automatic logic [2:0] set_fault(input logic [2:0] cur, input logic [2:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  // Signed 24-bit PCM scaled by 2^-15 or 2^-23 to IEEE single; exact.
  function automatic logic [31:0] pcm_to_f32(input logic [23:0] v, input logic is16);
    logic        s;
    logic [23:0] m;
    logic [4:0]  p;
    logic [23:0] nm;
    logic [7:0]  e;
    s = v[23];
    m = s ? (~v + 24'd1) : v;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) p = 5'(i);
    end
    nm = m << (5'd23 - p);
    e  = 8'd127 + {3'd0, p} - (is16 ? 8'd15 : 8'd23);
    return (m == 24'd0) ? 32'd0 : {s, e, nm[22:0]};
  endfunction

  function automatic logic [31:0] decode_sample(input logic [31:0] raw,
                                                input logic [15:0] fmt,
                                                input logic [15:0] bits);
    logic        is16;
    logic [23:0] v;
    is16 = (bits == 16'd16);
    v    = is16 ? {{8{raw[15]}}, raw[15:0]} : raw[23:0];
    if (fmt == FMT_FLOAT) begin
      return ((raw & 32'h7f800000) == 32'h7f800000) ? 32'd0 : raw;
    end
    return pcm_to_f32(v, is16);
  endfunction

endpackage

// ===== src/wsd_ctrl.sv =====
// Controller: handshake and sequencing of accept, divide, finish and result steps.
module wsd_ctrl import wsd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  wsd_sts_t sts,
  output wsd_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (sts.need_div) state_nxt = ST_DIV;
          else if (sts.has_res) state_nxt = ST_RES;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = sts.has_res ? ST_RES : ST_IDLE;
      end
      ST_RES: begin
        cmd.res = sts.out_free;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/wsd_datapath.sv =====
// Datapath: RIFF/WAVE parse state, frame divider, sample conversion and output register.
module wsd_datapath import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  in_t         in_data,
  input  wsd_cmd_t    cmd,
  output wsd_sts_t    sts,
  input  logic        out_stall,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic [31:0] frame_limit
);

  logic [31:0] limit_r, limit_nxt;
  logic [5:0]  pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [15:0] align_r, align_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic        ext_ok_r, ext_ok_nxt;
  logic        seen_fmt_r, seen_fmt_nxt;
  logic        seen_data_r, seen_data_nxt;
  logic        ext_len_r, ext_len_nxt;
  logic [2:0]  fault_r, fault_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  kind_t       kind_r, kind_nxt;
  logic        pad_r, pad_nxt;
  logic [5:0]  pidx_r, pidx_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [63:0] asm_r, asm_nxt;
  logic [15:0] sub_r, sub_nxt;
  logic [63:0] frame_r, frame_nxt;
  logic        fvalid_r, fvalid_nxt;
  logic        last_r, last_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, out_nxt;

  logic [31:0] tag_n;
  logic [31:0] expect_w;
  logic        align_bad;
  logic        fmt_ok;
  logic        need_div;
  logic        has_res;
  logic [63:0] prod3;
  logic [31:0] q3;
  logic [31:0] dq;
  logic [31:0] dm;
  logic [31:0] dr;
  logic [2:0]  f;
  logic        ext_n;
  logic [2:0]  bps;
  logic [31:0] raw_l;
  logic [31:0] raw_r;
  logic [31:0] dec_l;
  logic [31:0] dec_r;
  logic        trunc;
  logic [2:0]  st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= FRAME_LIMIT_RST;
      pos_r       <= '0;
      phase_r     <= PH_RIFF;
      tag_r       <= '0;
      remain_r    <= '0;
      fmt_r       <= '0;
      chan_r      <= '0;
      bits_r      <= '0;
      align_r     <= '0;
      rate_r      <= '0;
      ext_ok_r    <= 1'b1;
      seen_fmt_r  <= 1'b0;
      seen_data_r <= 1'b0;
      ext_len_r   <= 1'b0;
      fault_r     <= ST_OK;
      hcnt_r      <= '0;
      kind_r      <= KIND_OTHER;
      pad_r       <= 1'b0;
      pidx_r      <= '0;
      fill_r      <= '0;
      asm_r       <= '0;
      sub_r       <= '0;
      fvalid_r    <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      tag_r       <= tag_nxt;
      remain_r    <= remain_nxt;
      fmt_r       <= fmt_nxt;
      chan_r      <= chan_nxt;
      bits_r      <= bits_nxt;
      align_r     <= align_nxt;
      rate_r      <= rate_nxt;
      ext_ok_r    <= ext_ok_nxt;
      seen_fmt_r  <= seen_fmt_nxt;
      seen_data_r <= seen_data_nxt;
      ext_len_r   <= ext_len_nxt;
      fault_r     <= fault_nxt;
      hcnt_r      <= hcnt_nxt;
      kind_r      <= kind_nxt;
      pad_r       <= pad_nxt;
      pidx_r      <= pidx_nxt;
      fill_r      <= fill_nxt;
      asm_r       <= asm_nxt;
      sub_r       <= sub_nxt;
      fvalid_r    <= fvalid_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    out_r   <= out_nxt;
  end

  assign tag_n     = {in_data.file_byte, tag_r[31:8]};
  assign expect_w  = (32'(chan_r) * 32'(bits_r)) >> 3;
  assign align_bad = (expect_w != {16'd0, align_r});
  assign fmt_ok    = ((fmt_r == FMT_PCM) && (bits_r == 16'd16 || bits_r == 16'd24))
                  || ((fmt_r == FMT_FLOAT) && (bits_r == 16'd32));

  // frame count: block alignment is 2, 3, 4, 6 or 8 once the header checks pass
  assign prod3 = 64'(quo_r) * 64'(32'haaaaaaab);
  assign q3    = 32'(prod3 >> 33);

  always_comb begin
    case (align_r[3:0])
      4'd2: begin
        dq = quo_r >> 1;
        dm = dq << 1;
      end
      4'd3: begin
        dq = q3;
        dm = (q3 << 1) + q3;
      end
      4'd4: begin
        dq = quo_r >> 2;
        dm = dq << 2;
      end
      4'd6: begin
        dq = q3 >> 1;
        dm = (dq << 2) + (dq << 1);
      end
      4'd8: begin
        dq = quo_r >> 3;
        dm = dq << 3;
      end
      default: begin
        dq = quo_r;
        dm = quo_r;
      end
    endcase
  end

  assign dr = quo_r - dm;

  assign bps   = bits_r[5:3];
  assign raw_l = frame_r[31:0];
  assign raw_r = 32'(frame_r >> {bps, 3'b000});
  assign dec_l = decode_sample(raw_l, fmt_r, bits_r);
  assign dec_r = (chan_r == 16'd2) ? decode_sample(raw_r, fmt_r, bits_r) : dec_l;
  assign trunc = (phase_r == PH_FMT || phase_r == PH_DATA || phase_r == PH_SKIP)
              && (remain_r != 32'd0);

  always_comb begin
    if (fault_r == ST_NOT_RIFF || pos_r < MIN_FILE_LEN) st = ST_NOT_RIFF;
    else if (trunc) st = ST_TRUNC;
    else if (fault_r != ST_OK) st = fault_r;
    else if (!seen_data_r) st = ST_UNSUPP;
    else st = ST_OK;
  end

  always_comb begin
    limit_nxt     = cfg_we ? cfg_wdata : limit_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    tag_nxt       = tag_r;
    remain_nxt    = remain_r;
    fmt_nxt       = fmt_r;
    chan_nxt      = chan_r;
    bits_nxt      = bits_r;
    align_nxt     = align_r;
    rate_nxt      = rate_r;
    ext_ok_nxt    = ext_ok_r;
    seen_fmt_nxt  = seen_fmt_r;
    seen_data_nxt = seen_data_r;
    ext_len_nxt   = ext_len_r;
    fault_nxt     = fault_r;
    hcnt_nxt      = hcnt_r;
    kind_nxt      = kind_r;
    pad_nxt       = pad_r;
    pidx_nxt      = pidx_r;
    fill_nxt      = fill_r;
    asm_nxt       = asm_r;
    sub_nxt       = sub_r;
    frame_nxt     = frame_r;
    fvalid_nxt    = fvalid_r;
    last_nxt      = last_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    need_div      = 1'b0;
    has_res       = in_data.is_last_byte;
    f             = fault_r;
    ext_n         = ext_ok_r;

    if (cmd.accept) begin
      tag_nxt    = tag_n;
      fvalid_nxt = 1'b0;
      last_nxt   = in_data.is_last_byte;
      if (pos_r != 6'h3f) pos_nxt = pos_r + 6'd1;
      case (phase_r)
        PH_RIFF: begin
          if (pos_r == 6'd3 && tag_n != TAG_RIFF) begin
            fault_nxt = set_fault(fault_r, ST_NOT_RIFF);
            phase_nxt = PH_DEAD;
          end else if (pos_r == 6'd11) begin
            if (tag_n != TAG_WAVE) begin
              fault_nxt = set_fault(fault_r, ST_NOT_RIFF);
              phase_nxt = PH_DEAD;
            end else begin
              phase_nxt = PH_HEAD;
              hcnt_nxt  = '0;
            end
          end
        end
        PH_HEAD: begin
          if (hcnt_r == 3'd3) begin
            kind_nxt = (tag_n == TAG_FMT) ? KIND_FMT
                     : ((tag_n == TAG_DATA) ? KIND_DATA : KIND_OTHER);
          end
          if (hcnt_r == 3'd7) begin
            remain_nxt = tag_n;
            pad_nxt    = tag_n[0];
            pidx_nxt   = '0;
            hcnt_nxt   = '0;
            phase_nxt  = PH_SKIP;
            if (kind_r == KIND_FMT && tag_n >= 32'd16) begin
              if (seen_data_r) begin
                fault_nxt = set_fault(fault_r, ST_UNSUPP);
              end else begin
                seen_fmt_nxt = 1'b1;
                ext_len_nxt  = (tag_n >= 32'd40);
                ext_ok_nxt   = 1'b1;
                phase_nxt    = PH_FMT;
              end
            end else if (kind_r == KIND_DATA) begin
              fill_nxt = '0;
              asm_nxt  = '0;
              if (!seen_fmt_r || seen_data_r) f = set_fault(f, ST_UNSUPP);
              seen_data_nxt = 1'b1;
              if (!fmt_ok || (chan_r != 16'd1 && chan_r != 16'd2) || rate_r == 32'd0
                  || align_r == 16'd0 || tag_n == 32'd0) f = set_fault(f, ST_UNSUPP);
              if (align_r != 16'd0 && align_bad) f = set_fault(f, ST_ALIGN);
              fault_nxt = f;
              if (f == ST_OK) begin
                need_div = 1'b1;
                quo_nxt  = tag_n;
                rem_nxt  = '0;
              end
            end
            if (tag_n == 32'd0) phase_nxt = PH_HEAD;
          end else begin
            hcnt_nxt = hcnt_r + 3'd1;
          end
        end
        PH_FMT, PH_DATA, PH_SKIP: begin
          if (remain_r != 32'd0) begin
            remain_nxt = remain_r - 32'd1;
            if (phase_r == PH_FMT) begin
              case (pidx_r)
                6'd1:  fmt_nxt   = tag_n[31:16];
                6'd3:  chan_nxt  = tag_n[31:16];
                6'd7:  rate_nxt  = tag_n;
                6'd13: align_nxt = tag_n[31:16];
                6'd15: bits_nxt  = tag_n[31:16];
                6'd17: if (tag_n[31:16] < 16'd22) ext_ok_nxt = 1'b0;
                6'd27: begin
                  sub_nxt = tag_n[15:0];
                  if (tag_n > 32'd3) ext_ok_nxt = 1'b0;
                end
                6'd31: if (tag_n != GUID_W1) ext_ok_nxt = 1'b0;
                6'd35: if (tag_n != GUID_W2) ext_ok_nxt = 1'b0;
                6'd39: begin
                  ext_n      = ext_ok_r && (tag_n == GUID_W3);
                  ext_ok_nxt = ext_n;
                  if (fmt_r == FMT_EXT && ext_len_r && ext_n) fmt_nxt = sub_r;
                end
                default: ;
              endcase
            end else if (phase_r == PH_DATA) begin
              asm_nxt  = asm_r | ({56'd0, in_data.file_byte} << {fill_r[2:0], 3'b000});
              fill_nxt = fill_r + 4'd1;
              if ({12'd0, fill_nxt} >= align_r) begin
                frame_nxt  = asm_nxt;
                fvalid_nxt = 1'b1;
                has_res    = 1'b1;
                fill_nxt   = '0;
                asm_nxt    = '0;
              end
            end
            if (pidx_r != 6'h3f) pidx_nxt = pidx_r + 6'd1;
            if (remain_nxt == 32'd0 && !pad_r) phase_nxt = PH_HEAD;
          end else begin
            pad_nxt   = 1'b0;
            phase_nxt = PH_HEAD;
          end
        end
        default: ;
      endcase
    end

    if (cmd.div_step) begin
      quo_nxt = dq;
      rem_nxt = dr[15:0];
    end

    if (cmd.fin) begin
      if (rem_r != 16'd0) fault_nxt = ST_ALIGN;
      else if (quo_r > limit_r) fault_nxt = ST_LIMIT;
      phase_nxt = ((rem_r != 16'd0) || (quo_r > limit_r)) ? PH_SKIP : PH_DATA;
    end

    if (cmd.res) begin
      out_valid_nxt            = 1'b1;
      out_nxt.frame_valid      = fvalid_r;
      out_nxt.left_sample      = fvalid_r ? dec_l : 32'd0;
      out_nxt.right_sample     = fvalid_r ? dec_r : 32'd0;
      out_nxt.end_of_file      = last_r;
      out_nxt.status           = last_r ? st : ST_OK;
      out_nxt.sample_rate      = (last_r && st == ST_OK) ? rate_r : 32'd0;
      if (last_r) begin
        pos_nxt       = '0;
        phase_nxt     = PH_RIFF;
        tag_nxt       = '0;
        remain_nxt    = '0;
        fmt_nxt       = '0;
        chan_nxt      = '0;
        bits_nxt      = '0;
        align_nxt     = '0;
        rate_nxt      = '0;
        ext_ok_nxt    = 1'b1;
        seen_fmt_nxt  = 1'b0;
        seen_data_nxt = 1'b0;
        ext_len_nxt   = 1'b0;
        fault_nxt     = ST_OK;
        hcnt_nxt      = '0;
        kind_nxt      = KIND_OTHER;
        pad_nxt       = 1'b0;
        pidx_nxt      = '0;
        fill_nxt      = '0;
        asm_nxt       = '0;
        sub_nxt       = '0;
      end
    end
  end

  always_comb begin
    sts.need_div = need_div;
    sts.has_res  = cmd.accept ? has_res : last_r;
    sts.div_done = 1'b1;
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid   = out_valid_r;
  assign out_data    = out_r;
  assign frame_limit = limit_r;

endmodule

// ===== src/wav_stream_sample_decoder_top.sv =====
// Top level of the WAV stream sample decoder: controller, datapath and register port.
// Takes one file byte per cycle while in_stall is low. A byte that completes a frame or ends the
// file passes through the result stage before the next byte is taken, and waits there while the
// output register still holds an earlier transfer under out_stall; the last byte of a data chunk
// header that passes the early checks passes first through the frame-count divider (shift or
// reciprocal multiply for the few legal block alignments) and then the step that finishes the
// header check. The output register holds a finished transfer while the next byte is
// taken. frame_limit sits at byte address 0 and resets to 1048576.
module wav_stream_sample_decoder_top import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  wsd_cmd_t    cmd;
  wsd_sts_t    sts;
  logic        cfg_we;
  logic [31:0] limit;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : limit;

  wsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  wsd_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata),
    .frame_limit (limit)
  );

`include "wav_stream_sample_decoder_top_assert.svh"

  `WSD_ASSERT_SAME(a_status_only_at_end, out_valid && !out_data.end_of_file, out_data.status == ST_OK && out_data.sample_rate == 32'd0, "status outside end of file")
  `WSD_ASSERT_SAME(a_idle_samples_zero, out_valid && !out_data.frame_valid, out_data.left_sample == 32'd0 && out_data.right_sample == 32'd0, "samples without frame")
  `WSD_ASSERT_NEXT(a_last_byte_stalls, in_valid && !in_stall && in_data.is_last_byte, in_stall, "last byte taken without result stage")

endmodule
